>>> design/wrtc_pkg.sv
// Types and state codes for the wildcard rule table classifier.
package wrtc_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned PORT_W = 16;

    typedef enum logic
    {
        OP_ADD      = 1'b0,
        OP_CLASSIFY = 1'b1
    } opcode_t;

    typedef struct packed
    {
        opcode_t             opcode;
        logic [ADDR_W-1:0]   source_address;
        logic [ADDR_W-1:0]   dest_address;
        logic [PORT_W-1:0]   source_port;
        logic [PORT_W-1:0]   dest_port;
    } req_t;

    typedef struct packed
    {
        logic hit;
        logic status;
    } rsp_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0]   source_address;
        logic [ADDR_W-1:0]   dest_address;
        logic [PORT_W-1:0]   source_port;
        logic [PORT_W-1:0]   dest_port;
    } rule_t;

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } state_t;

endpackage

>>> design/wildcard_rule_table_classifier.sv
// Wildcard rule table classifier: rule store, scan sequencer and result register.
//
//  channel | direction | payload | handshake
//  --------+-----------+---------+------------------------------
//  req     | in        | req_t   | req_valid / req_stall
//  rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
// An accepted add sets its result register and passes it on from the done state to the output register.
// A classify walks the stored rules one per cycle through the single memory read
// port and one shared compare unit, and stops at the first rule that hits.
// Reset clears the rule count and control state; the rule memory is not cleared.
// req_stall is high while an item is in work; a held result does not block a new
// request, which waits in the done state only if the output register is still full.
module wildcard_rule_table_classifier
    import wrtc_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    rule_t rule_mem [TABLE_DEPTH];

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             rd_last_reg, rd_last_next;
    rule_t            rd_data_reg;
    rule_t            pkt_reg, pkt_next;
    rsp_t             result_reg, result_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic             accept;
    logic             mem_wr;
    logic             rd_en;
    logic             match;
    logic             slot_free;

    assign accept    = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign mem_wr    = accept && (req.opcode == OP_ADD) && (count_reg != DEPTH_CNT);

    // Shared compare unit: zero in a rule field matches anything.
    assign match = ((rd_data_reg.source_address == '0)
                    || (rd_data_reg.source_address == pkt_reg.source_address))
                && ((rd_data_reg.dest_address == '0)
                    || (rd_data_reg.dest_address == pkt_reg.dest_address))
                && ((rd_data_reg.source_port == '0)
                    || (rd_data_reg.source_port == pkt_reg.source_port))
                && ((rd_data_reg.dest_port == '0)
                    || (rd_data_reg.dest_port == pkt_reg.dest_port));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        rd_valid_next  = 1'b0;
        rd_last_next   = rd_last_reg;
        rd_en          = 1'b0;
        pkt_next       = pkt_reg;
        result_next    = result_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        req_stall      = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pkt_next.source_address = req.source_address;
                    pkt_next.dest_address   = req.dest_address;
                    pkt_next.source_port    = req.source_port;
                    pkt_next.dest_port      = req.dest_port;
                    result_next             = '0;
                    issue_next              = '0;
                    if (req.opcode == OP_ADD)
                    begin
                        if (count_reg == DEPTH_CNT)
                        begin
                            result_next.status = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (rd_valid_reg && (match || rd_last_reg))
                begin
                    result_next.hit = match;
                    state_next      = ST_DONE;
                end
                else if (issue_reg != count_reg)
                begin
                    // Issue the next read while the previous rule is compared.
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_last_next  = (CNT_W'(issue_reg + 1'b1) == count_reg);
                    issue_next    = issue_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = result_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            rd_valid_reg  <= rd_valid_next;
            rd_last_reg   <= rd_last_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg    <= pkt_next;
        result_reg <= result_next;
        rsp_reg    <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            rule_mem[count_reg[IDX_W-1:0]] <= '{req.source_address, req.dest_address,
                                                req.source_port, req.dest_port};
        end
        if (rd_en)
        begin
            rd_data_reg <= rule_mem[issue_reg[IDX_W-1:0]];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Rule count never passes the table depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_CNT)
        else $error("rule count beyond table depth");

    // The read issue pointer never runs past the stored rules.
    assert property (@(posedge clk) disable iff (!rst_n) issue_reg <= count_reg)
        else $error("scan pointer past stored rules");

    // A compare result is only pending during a scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == ST_SCAN))
        else $error("read data pending outside scan");

    // A result never reports both a hit and a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.hit && rsp_reg.status))
        else $error("hit and full status together");

    // An accepted add on a table with room grows the count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("add did not advance rule count");

endmodule
